[hw/rtl/spmqa_pkg.sv]
// ----------------------------------------------------------------------------
// spmqa_pkg
// Types and constants shared by the strict priority queue arbiter modules.
// ----------------------------------------------------------------------------
package spmqa_pkg;

  localparam int unsigned QIDX_W  = 3;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned PTR_W   = 4;
  localparam int unsigned PRIO_W  = 3;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned PRIO_REG_W  = 24;
  localparam int unsigned DEPTH_REG_W = 40;
  localparam int unsigned CFG_DATA_W  = 40;
  localparam int unsigned MSG_W   = 32;
  localparam int unsigned KIND_W  = 3;

  typedef enum logic [1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_STATUS = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_SEND     = 3'd0,
    KIND_OVERFLOW = 3'd1,
    KIND_RETURN   = 3'd2,
    KIND_HWM      = 3'd3,
    KIND_STATUS   = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    CFG_PRIO  = 1'b0,
    CFG_DEPTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WARN,
    ST_SEND,
    ST_RET,
    ST_TICK,
    ST_STERR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       capture;   // latch input request
    logic       push;      // write handle into queue
    logic       set_thr;   // set overflow throttle
    logic       pop;       // pop winner queue, clear throttle
    logic       go_ready;
    logic       go_wait;
    logic       tick_clr;  // clear peak of tick counter queue
    logic       tick_inc;
    logic       tick_rst;
    logic       out_load;
    kind_e      kind;
    logic       last;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    func_e      func;
    logic       q_valid;   // queue number in range
    logic       full;
    logic       is_buf;
    logic       ready;
    logic       found;     // a non-empty queue exists
    logic       thr_clr;   // throttle of the request queue is clear
    logic       tick_end;
    logic       out_busy;
  } stat_t;

endpackage

[hw/rtl/spmqa_ram.sv]
// ----------------------------------------------------------------------------
// spmqa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module spmqa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/spmqa_ctrl.sv]
// ----------------------------------------------------------------------------
// spmqa_ctrl
// Sequencer: steps one request through its result phases.
// ----------------------------------------------------------------------------
module spmqa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  spmqa_pkg::stat_t stat_i,
  output spmqa_pkg::ctrl_t ctrl_o
);
  import spmqa_pkg::*;

  state_e state_q, state_d;
  logic   warn_q, warn_d;
  logic   ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      warn_q  <= 1'b0;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      warn_q  <= warn_d;
      ret_q   <= ret_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    warn_d     = warn_q;
    ret_d      = ret_q;
    ctrl_o     = '0;
    ctrl_o.kind = KIND_SEND;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        case (stat_i.func)
          FUNC_ENQ: begin
            if (stat_i.q_valid) begin
              warn_d = 1'b0;
              ret_d  = 1'b0;
              if (stat_i.full) begin
                ret_d = stat_i.is_buf;
              end else begin
                ctrl_o.push = 1'b1;
              end
              state_d = stat_i.full ? ST_WARN : ST_SEND;
            end
          end
          FUNC_STATUS: begin
            if (stat_i.ready) begin
              state_d = ST_STERR;
            end else if (stat_i.is_buf) begin
              // is_buf carries status_success for status requests
              ctrl_o.go_ready = 1'b1;
              ret_d = 1'b0;
              state_d = ST_SEND;
            end
          end
          FUNC_TICK: begin
            ctrl_o.tick_rst = 1'b1;
            state_d = ST_TICK;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_WARN: begin
        if (stat_i.thr_clr) begin
          if (!stat_i.out_busy) begin
            ctrl_o.set_thr  = 1'b1;
            ctrl_o.out_load = 1'b1;
            ctrl_o.kind     = KIND_OVERFLOW;
            ctrl_o.last     = !(stat_i.ready && stat_i.found) && !ret_q;
            state_d = ST_SEND;
          end
        end else begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (stat_i.ready && stat_i.found) begin
          if (!stat_i.out_busy) begin
            ctrl_o.pop      = 1'b1;
            ctrl_o.go_wait  = 1'b1;
            ctrl_o.out_load = 1'b1;
            ctrl_o.kind     = KIND_SEND;
            ctrl_o.last     = !ret_q;
            state_d = ret_q ? ST_RET : ST_IDLE;
          end
        end else begin
          state_d = ret_q ? ST_RET : ST_IDLE;
        end
      end
      ST_RET: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.kind     = KIND_RETURN;
          ctrl_o.last     = 1'b1;
          ret_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.kind     = KIND_HWM;
          ctrl_o.last     = stat_i.tick_end;
          ctrl_o.tick_clr = 1'b1;
          ctrl_o.tick_inc = 1'b1;
          if (stat_i.tick_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_STERR: begin
        if (!stat_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.kind     = KIND_STATUS;
          ctrl_o.last     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.pop |-> stat_i.ready && stat_i.found)
    else $error("pop without ready link or non-empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> !stat_i.out_busy)
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.capture |=> state_q == ST_EVAL)
    else $error("captured request not evaluated");
`endif

endmodule

[hw/rtl/spmqa_dp.sv]
// ----------------------------------------------------------------------------
// spmqa_dp
// Queue datapath: fill counters, pointers, throttles, peaks, arbitration,
// handle store and the output register.
// ----------------------------------------------------------------------------
module spmqa_dp #(
  parameter int unsigned QUEUE_COUNT = 8,
  parameter int unsigned COM_QUEUES  = 4,
  parameter int unsigned MAX_DEPTH   = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [spmqa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [1:0]                        in_func_i,
  input  logic [spmqa_pkg::QIDX_W-1:0]      in_queue_i,
  input  logic [spmqa_pkg::MSG_W-1:0]       in_handle_i,
  input  logic                              in_ok_i,
  input  spmqa_pkg::ctrl_t                  ctrl_i,
  output spmqa_pkg::stat_t                  stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [spmqa_pkg::KIND_W-1:0]      out_kind_o,
  output logic [spmqa_pkg::QIDX_W-1:0]      out_queue_o,
  output logic                              out_buf_o,
  output logic [spmqa_pkg::MSG_W-1:0]       out_msg_o,
  output logic [spmqa_pkg::FILL_W-1:0]      out_hw_o,
  output logic                              out_last_o
);
  import spmqa_pkg::*;

  localparam int unsigned ADDR_W = QIDX_W + SLOT_W;

  logic [PRIO_REG_W-1:0]  prio_q;
  logic [DEPTH_REG_W-1:0] depth_q;
  logic                   ready_q;
  logic [7:0]             thr_q;
  logic [FILL_W-1:0]      fill_q [8];
  logic [PTR_W-1:0]       rp_q   [8];
  logic [FILL_W-1:0]      peak_q [8];

  logic [1:0]             func_q;
  logic [QIDX_W-1:0]      qn_q;
  logic [MSG_W-1:0]       hnd_q;
  logic                   ok_q;
  logic [QIDX_W-1:0]      tick_q;

  logic                   ov_q;
  logic [KIND_W-1:0]      kind_q;
  logic [QIDX_W-1:0]      oq_q;
  logic                   obuf_q;
  logic [MSG_W-1:0]       omsg_q;
  logic [FILL_W-1:0]      ohw_q;
  logic                   olast_q;

  logic [FILL_W-1:0]      depth_sat;
  logic [FILL_W-1:0]      depth_raw;
  logic                   full;
  logic [QIDX_W-1:0]      best;
  logic                   found;
  logic [PRIO_W-1:0]      best_p;
  logic [FILL_W-1:0]      wp_sum;
  logic [PTR_W-1:0]       wp;
  logic [PTR_W-1:0]       rp_best;
  logic [ADDR_W-1:0]      waddr;
  logic [ADDR_W-1:0]      raddr;
  logic [MSG_W-1:0]       rdata;
  logic [MSG_W-1:0]       hmask;
  logic                   ram_pending_q;
  logic                   send_fix_q;

  assign hmask = (HANDLE_BITS >= MSG_W) ? '1 : MSG_W'((64'd1 << HANDLE_BITS) - 64'd1);

  // strict priority scan, lower value then lower index
  always_comb begin
    best   = '0;
    found  = 1'b0;
    best_p = '0;
    for (int q = 0; q < 8; q++) begin
      if (q < QUEUE_COUNT && fill_q[q] != '0) begin
        if (!found || prio_q[3*q +: 3] < best_p) begin
          best   = QIDX_W'(q);
          best_p = prio_q[3*q +: 3];
          found  = 1'b1;
        end
      end
    end
  end

  assign depth_raw = depth_q[5*qn_q +: 5];
  assign depth_sat = (depth_raw > FILL_W'(MAX_DEPTH)) ? FILL_W'(MAX_DEPTH) : depth_raw;
  assign full      = fill_q[qn_q] >= depth_sat;
  assign wp_sum    = FILL_W'(rp_q[qn_q]) + fill_q[qn_q];
  assign wp        = (32'(wp_sum) >= MAX_DEPTH) ? PTR_W'(32'(wp_sum) - MAX_DEPTH)
                                                : PTR_W'(wp_sum);
  assign waddr     = {qn_q, wp};
  assign rp_best   = rp_q[best];
  assign raddr     = {best, rp_best};

  spmqa_ram #(.WIDTH(MSG_W), .DEPTH(1 << ADDR_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (waddr),
    .wdata_i (hnd_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      func_q <= in_func_i;
      qn_q   <= in_queue_i;
      hnd_q  <= in_handle_i & hmask;
      ok_q   <= in_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q  <= '0;
      depth_q <= '0;
      ready_q <= 1'b0;
      thr_q   <= '0;
      tick_q  <= '0;
      ov_q    <= 1'b0;
      ram_pending_q <= 1'b0;
      for (int q = 0; q < 8; q++) begin
        fill_q[q] <= '0;
        rp_q[q]   <= '0;
        peak_q[q] <= '0;
      end
    end else begin
      ram_pending_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PRIO) prio_q <= cfg_data_i[PRIO_REG_W-1:0];
        else depth_q <= cfg_data_i[DEPTH_REG_W-1:0];
      end
      if (ctrl_i.go_ready) ready_q <= 1'b1;
      if (ctrl_i.go_wait)  ready_q <= 1'b0;
      if (ctrl_i.set_thr)  thr_q[qn_q] <= 1'b1;
      if (ctrl_i.push) begin
        fill_q[qn_q] <= fill_q[qn_q] + 1'b1;
        if (fill_q[qn_q] + 1'b1 > peak_q[qn_q]) peak_q[qn_q] <= fill_q[qn_q] + 1'b1;
      end
      if (ctrl_i.pop) begin
        fill_q[best] <= fill_q[best] - 1'b1;
        rp_q[best]   <= (32'(rp_best) + 32'd1 >= MAX_DEPTH) ? '0 : rp_best + 1'b1;
        thr_q[best]  <= 1'b0;
      end
      if (ctrl_i.tick_rst) tick_q <= '0;
      if (ctrl_i.tick_clr) peak_q[tick_q] <= '0;
      if (ctrl_i.tick_inc) tick_q <= tick_q + 1'b1;
      if (ctrl_i.out_load) ov_q <= 1'b1;
      else if (out_ready_i && !send_fix_q) ov_q <= 1'b0;
    end
  end

  // send data comes from the RAM's registered read of the pop address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) send_fix_q <= 1'b0;
    else send_fix_q <= ctrl_i.pop;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      kind_q  <= ctrl_i.kind;
      olast_q <= ctrl_i.last;
      omsg_q  <= '0;
      ohw_q   <= '0;
      case (ctrl_i.kind)
        KIND_SEND: begin
          oq_q   <= best;
          obuf_q <= 32'(best) >= COM_QUEUES;
        end
        KIND_RETURN: begin
          oq_q   <= qn_q;
          obuf_q <= 32'(qn_q) >= COM_QUEUES;
          omsg_q <= hnd_q;
        end
        KIND_HWM: begin
          oq_q   <= tick_q;
          obuf_q <= 32'(tick_q) >= COM_QUEUES;
          ohw_q  <= peak_q[tick_q];
        end
        KIND_STATUS: begin
          oq_q   <= '0;
          obuf_q <= 1'b0;
        end
        default: begin
          oq_q   <= qn_q;
          obuf_q <= 32'(qn_q) >= COM_QUEUES;
        end
      endcase
    end else if (send_fix_q) begin
      omsg_q <= rdata;
    end
  end

  // RAM read is registered; hold output valid until data lands
  assign out_valid_o = ov_q && !send_fix_q;
  assign out_kind_o  = kind_q;
  assign out_queue_o = oq_q;
  assign out_buf_o   = obuf_q;
  assign out_msg_o   = omsg_q;
  assign out_hw_o    = ohw_q;
  assign out_last_o  = olast_q;

  always_comb begin
    stat_o          = '0;
    stat_o.func     = func_e'(func_q);
    stat_o.q_valid  = 32'(qn_q) < QUEUE_COUNT;
    stat_o.full     = full;
    stat_o.ready    = ready_q;
    stat_o.tick_end = 32'(tick_q) == QUEUE_COUNT - 1;
    stat_o.out_busy = (ov_q && !out_ready_i) || send_fix_q || ram_pending_q;
    // buffer flag, or status ok for status requests
    stat_o.is_buf   = (func_q == FUNC_STATUS) ? ok_q : (32'(qn_q) >= COM_QUEUES);
    stat_o.found    = found;
    stat_o.thr_clr  = !thr_q[qn_q];
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> fill_q[best] != '0)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |=> !ready_q)
    else $error("link stays ready after send");
`endif

endmodule

[hw/rtl/strict_priority_message_queue_arbiter.sv]
// ----------------------------------------------------------------------------
// strict_priority_message_queue_arbiter
// Strict priority arbiter over message handle queues.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: func, queue number, handle, link status.
//   m_axis carries results (send, overflow warning, handle returned,
//   high-water report, status error); tlast marks the last result of a
//   request. A request gives zero to eight results.
//   Configuration: cfg_we_i with index 0 (priorities) or 1 (depths),
//   written only while idle.
//   Timing: a request is taken while the sequencer is idle and evaluated in
//   the next cycle; each result is then loaded into the output register,
//   a send waiting further for the handle RAM read.
//   The sequencer handles one request at a time; s_axis_tready is high only
//   when the previous request has issued all its results.
//   Reset clears all queues, throttles, peaks and the link state.
//   When m_axis_tready is low the result holds and the sequencer waits.
// ----------------------------------------------------------------------------
module strict_priority_message_queue_arbiter #(
  parameter int unsigned QUEUE_COUNT = 8,
  parameter int unsigned COM_QUEUES  = 4,
  parameter int unsigned MAX_DEPTH   = 16,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [39:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // func[1:0], queue_number[4:2],
                                      // message_handle[36:5], status_success[37]
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  output logic [47:0] m_axis_tdata,   // result_kind[2:0], source_queue[5:3],
                                      // is_buffer_queue[6], message_out[38:7],
                                      // high_water[43:39]
  output logic        m_axis_tlast
);
  import spmqa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic [KIND_W-1:0] kind;
  logic [QIDX_W-1:0] oq;
  logic              obuf;
  logic [MSG_W-1:0]  omsg;
  logic [FILL_W-1:0] ohw;

  spmqa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  spmqa_dp #(
    .QUEUE_COUNT (QUEUE_COUNT),
    .COM_QUEUES  (COM_QUEUES),
    .MAX_DEPTH   (MAX_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_func_i   (s_axis_tdata[1:0]),
    .in_queue_i  (s_axis_tdata[4:2]),
    .in_handle_i (s_axis_tdata[36:5]),
    .in_ok_i     (s_axis_tdata[37]),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (kind),
    .out_queue_o (oq),
    .out_buf_o   (obuf),
    .out_msg_o   (omsg),
    .out_hw_o    (ohw),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, ohw, omsg, obuf, oq, kind};

endmodule

[verif/spmqa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmqa_checker
// Watches the request and result streams of the queue arbiter, predicts the
// results of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module spmqa_checker
  import spmqa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [39:0] cfg_data_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [39:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [47:0] m_data_i,
  input  logic        m_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          sends_o,
  output int          results_o
);

  localparam int NQ = 8;
  localparam int NCOM = 4;
  localparam int MAXD = 16;

  typedef struct packed {
    logic        last;
    logic [4:0]  hw;
    logic [31:0] msg;
    logic        is_buf;
    logic [2:0]  q;
    kind_e       kind;
  } result_t;

  result_t     expected_q[$];
  logic [23:0] prio_reg;
  logic [39:0] depth_reg;
  logic        link_rdy;
  logic        throttle[NQ];
  logic [31:0] store[NQ*16];
  int          fill[NQ];
  int          rptr[NQ];
  int          peak[NQ];

  function automatic int depth_of(int q);
    int d;
    d = int'((depth_reg >> (5*q)) & 40'd31);
    return d > MAXD ? MAXD : d;
  endfunction

  function automatic int prio_of(int q);
    return int'((prio_reg >> (3*q)) & 24'd7);
  endfunction

  function automatic void push_result(kind_e k, int q, logic [31:0] m, int hw);
    result_t r;
    r.kind = k;
    r.q = 3'(q);
    r.is_buf = (k == KIND_STATUS) ? 1'b0 : (q >= NCOM);
    r.msg = m;
    r.hw = 5'(hw);
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void serve_best();
    int best;
    best = -1;
    if (!link_rdy) return;
    for (int q = 0; q < NQ; q++)
      if (fill[q] != 0 && (best < 0 || prio_of(q) < prio_of(best))) best = q;
    if (best < 0) return;
    push_result(KIND_SEND, best, store[best*16 + rptr[best]], 0);
    rptr[best] = (rptr[best] + 1) % MAXD;
    fill[best]--;
    throttle[best] = 1'b0;
    link_rdy = 1'b0;
    sends_o++;
  endfunction

  function automatic void predict_request(logic [39:0] d);
    func_e       f;
    int          q, n0;
    logic [31:0] h;
    logic        ok, dropped;
    f = func_e'(d[1:0]);
    q = int'(d[4:2]);
    h = d[36:5];
    ok = d[37];
    n0 = expected_q.size();
    dropped = 1'b0;
    case (f)
      FUNC_ENQ: begin
        if (fill[q] < depth_of(q)) begin
          store[q*16 + (rptr[q] + fill[q]) % MAXD] = h;
          fill[q]++;
          if (fill[q] > peak[q]) peak[q] = fill[q];
        end else begin
          dropped = 1'b1;
          if (!throttle[q]) begin
            throttle[q] = 1'b1;
            push_result(KIND_OVERFLOW, q, '0, 0);
          end
        end
        serve_best();
        if (dropped && q >= NCOM) push_result(KIND_RETURN, q, h, 0);
      end
      FUNC_STATUS: begin
        if (link_rdy) push_result(KIND_STATUS, 0, '0, 0);
        else if (ok) begin
          link_rdy = 1'b1;
          serve_best();
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < NQ; i++) begin
          push_result(KIND_HWM, i, '0, peak[i]);
          peak[i] = 0;
        end
      end
      default: ;
    endcase
    if (expected_q.size() > n0) expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp_r;
    if (!rst_ni) begin
      prio_reg <= '0;
      depth_reg <= '0;
      link_rdy = 1'b0;
      for (int i = 0; i < NQ; i++) begin
        throttle[i] = 1'b0;
        fill[i] = 0;
        rptr[i] = 0;
        peak[i] = 0;
      end
      expected_q.delete();
      fail_count_o <= 0;
      sends_o = 0;
      results_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_PRIO) prio_reg <= cfg_data_i[23:0];
        else depth_reg <= cfg_data_i;
      end
      if (m_valid_i && m_ready_i) begin
        got = {m_last_i, m_data_i[43:39], m_data_i[38:7], m_data_i[6],
               m_data_i[5:3], kind_e'(m_data_i[2:0])};
        results_o++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: result mismatch, expected %h actual %h",
                     $time, exp_r, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (s_valid_i && s_ready_i) predict_request(s_data_i);
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives configuration, directed requests and random request bursts into the
// queue arbiter, with a stalling result sink, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import spmqa_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [39:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count, pending, sends, results;
  int          idle_cycles;
  int          hold_off = 0;
  int          stall_mode = 0;
  bit          done = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  strict_priority_message_queue_arbiter u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tready, .m_axis_tvalid, .m_axis_tdata, .m_axis_tlast
  );

  spmqa_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_last_i(m_axis_tlast), .fail_count_o(fail_count), .pending_o(pending),
    .sends_o(sends), .results_o(results)
  );

  // result sink: random stall patterns plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [39:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // called at a falling edge; tready is stable there until the next rising edge
  task automatic send_request(func_e f, int q, logic [31:0] h, logic ok);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, ok, h, q[2:0], f};
    while (!s_axis_tready) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_handle();
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly enqueues, link successes keep the arbiter moving
  task automatic random_burst(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 60) send_request(FUNC_ENQ, $urandom_range(0, 7), rand_handle(), $urandom);
      else if (r < 88) send_request(FUNC_STATUS, $urandom_range(0, 7), $urandom,
                                   $urandom_range(0, 4) != 0);
      else if (r < 96) send_request(FUNC_TICK, $urandom_range(0, 7), $urandom, $urandom);
      else send_request(FUNC_NONE, $urandom_range(0, 7), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: disabled queues, then mixed depths with equal priorities
    send_request(FUNC_ENQ, 0, 32'hFFFF_FFFF, 1'b1);
    send_request(FUNC_ENQ, 7, 32'h0, 1'b0);
    send_request(FUNC_STATUS, 0, 32'h0, 1'b0);
    send_request(FUNC_NONE, 3, 32'h1234_5678, 1'b1);
    send_request(FUNC_TICK, 0, 32'h0, 1'b0);
    drain();
    write_reg(CFG_PRIO, 40'h00_00FF_FFFF);
    write_reg(CFG_DEPTH, {5'd31, 5'd2, 5'd1, 5'd0, 5'd16, 5'd2, 5'd1, 5'd31});
    send_request(FUNC_STATUS, 0, 32'h0, 1'b1);
    send_request(FUNC_STATUS, 0, 32'h0, 1'b1);
    send_request(FUNC_ENQ, 5, 32'hAAAA_5555, 1'b0);
    send_request(FUNC_ENQ, 5, 32'h5555_AAAA, 1'b0);
    send_request(FUNC_ENQ, 5, 32'h0F0F_0F0F, 1'b0);
    send_request(FUNC_ENQ, 5, 32'hF0F0_F0F0, 1'b0);
    send_request(FUNC_ENQ, 1, 32'h1111_1111, 1'b0);
    send_request(FUNC_ENQ, 1, 32'h2222_2222, 1'b0);
    send_request(FUNC_ENQ, 4, 32'hDEAD_BEEF, 1'b0);
    send_request(FUNC_STATUS, 0, 32'h0, 1'b1);
    send_request(FUNC_STATUS, 0, 32'h0, 1'b1);
    send_request(FUNC_TICK, 0, 32'h0, 1'b0);
    drain();
    write_reg(CFG_DEPTH, {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0});
    send_request(FUNC_ENQ, 1, 32'h3333_3333, 1'b0);
    send_request(FUNC_STATUS, 0, 32'h0, 1'b1);
    send_request(FUNC_STATUS, 0, 32'h0, 1'b1);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_PRIO, ph == 0 ? 40'h0 : ph == 1 ? 40'hFF_FFFF : {16'h0, 24'($urandom)});
      write_reg(CFG_DEPTH, ph == 1 ? 40'hFF_FFFF_FFFF
                : {5'($urandom_range(0, 4)), 5'($urandom_range(0, 4)),
                   5'($urandom_range(0, 20)), 5'($urandom_range(0, 4)),
                   5'($urandom_range(0, 4)), 5'($urandom_range(1, 4)),
                   5'($urandom_range(0, 20)), 5'($urandom_range(1, 4))});
      if (ph == 2) hold_off = 300;
      random_burst(45);
      drain();
    end

    done = 1'b1;
    $display("Requests covered all functions over six random configurations;");
    $display("%0d results checked, %0d sends.", results, sends);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/spmqa_pkg.sv
hw/rtl/spmqa_ram.sv
hw/rtl/spmqa_ctrl.sv
hw/rtl/spmqa_dp.sv
hw/rtl/strict_priority_message_queue_arbiter.sv
verif/spmqa_checker.sv
verif/tb.sv
